[hw/rtl/cnr_pkg.sv]
// Types and constants shared by the curve number runoff block.
package cnr_pkg;

	typedef struct packed {
		logic signed [23:0] rainfall_depth;
		logic signed [15:0] curve_value;
	} pixel_t;

	typedef struct packed {
		logic signed [23:0] runoff_depth;
		logic               is_no_data;
	} runoff_t;

	// sideband carried through the retention divider
	typedef struct packed {
		logic [22:0] p;
		logic        no_data;
		logic        cn_zero;
	} side1_t;

	// sideband carried through the runoff divider
	typedef struct packed {
		logic no_data;
		logic zero_res;
		logic d_zero;
		logic d_neg;
	} side2_t;

	localparam int          RAIN_W  = 24;
	localparam int          NUM_W   = 52;
	localparam logic [23:0] MAX24   = 24'h7fffff;
	localparam logic [23:0] MIN24   = 24'h800000;
	localparam logic [23:0] ND_RST  = 24'hd8f100;
	localparam logic        REG_NO_DATA = 1'b0;

endpackage

[hw/rtl/cnr_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module cnr_div #(
	parameter int NW = 31,
	parameter int DW = 15,
	parameter int SW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [NW-1:0] quotient,
	output logic [SW-1:0] out_side
);

	logic          vld_s [0:NW];
	logic [NW-1:0] dvd_s [0:NW];
	logic [DW-1:0] dvs_s [0:NW];
	logic [DW-1:0] rem_s [0:NW];
	logic [NW-1:0] quo_s [0:NW];
	logic [SW-1:0] sd_s  [0:NW];

	assign vld_s[0] = in_vld;
	assign dvd_s[0] = dividend;
	assign dvs_s[0] = divisor;
	assign rem_s[0] = '0;
	assign quo_s[0] = '0;
	assign sd_s[0]  = in_side;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_s[i], dvd_s[i][NW-1]};
			ge    = trial >= {1'b0, dvs_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[i+1] <= dvd_s[i] << 1;
				dvs_s[i+1] <= dvs_s[i];
				rem_s[i+1] <= ge ? DW'(trial - {1'b0, dvs_s[i]}) : trial[DW-1:0];
				quo_s[i+1] <= {quo_s[i][NW-2:0], ge};
				sd_s[i+1]  <= sd_s[i];
			end
		end
	end

	assign out_vld  = vld_s[NW];
	assign quotient = quo_s[NW];
	assign out_side = sd_s[NW];

endmodule

[hw/rtl/curve_number_runoff_top.sv]
// Top level of the SCS curve number runoff pipeline.
//
// Usage:
//  - pixel channel: one request per cycle carries rainfall depth and curve
//    number; it is taken when pixel_valid is high and pixel_stall is low.
//  - runoff channel: one result per request, in order, held in an output
//    register until taken (runoff_valid high, runoff_stall low).
//  - APB port: register 0 at byte address 0 holds the 24-bit no-data value.
//  - Throughput: one request per cycle while the runoff side is not stalled. The
//    pipeline depth is set by the two bit-per-stage dividers:
//    retention 25400/CN, then the runoff quotient over a 52-bit numerator.
//  - A stall on the runoff side freezes the whole pipeline while the output
//    register is full; pixel_stall is raised in that cycle.
//  - Reset empties the pipeline and loads the no-data value -9999.0.
module curve_number_runoff_top #(
	parameter int FRAC_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pixel_valid,
	output logic            pixel_stall,
	input  cnr_pkg::pixel_t pixel,
	output logic            runoff_valid,
	input  logic            runoff_stall,
	output cnr_pkg::runoff_t runoff,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import cnr_pkg::*;

	localparam int      NW1   = 15 + 2 * FRAC_BITS;
	localparam int      XW    = NW1 + 5;
	localparam int      DW2   = XW + 2;
	localparam longint  N1    = longint'(25400) << (2 * FRAC_BITS);
	localparam longint  S_OFF = longint'(254) << FRAC_BITS;

	logic [23:0] no_data_q;
	logic        en;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_data_q <= ND_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_NO_DATA) begin
			no_data_q <= pwdata[23:0];
		end
	end
	assign prdata = (paddr[2] == REG_NO_DATA) ? {{8{no_data_q[23]}}, no_data_q} : '0;

	assign en          = !(runoff_valid && runoff_stall);
	assign pixel_stall = !en;

	// stage 1: capture request
	logic        v_s1;
	logic [14:0] cn_s1;
	side1_t      sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cn_s1         <= pixel.curve_value[14:0];
			sd_s1.p       <= pixel.rainfall_depth[22:0];
			sd_s1.no_data <= pixel.rainfall_depth[23] || pixel.curve_value[15];
			sd_s1.cn_zero <= pixel.curve_value == '0;
		end
	end

	// retention divider
	logic           v_d1;
	logic [NW1-1:0] q1;
	logic [$bits(side1_t)-1:0] sd1_raw;
	side1_t         sd_d1;

	cnr_div #(.NW(NW1), .DW(15), .SW($bits(side1_t))) u_div_s (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s1),
		.dividend (NW1'(N1)),
		.divisor  (cn_s1),
		.in_side  (sd_s1),
		.out_vld  (v_d1),
		.quotient (q1),
		.out_side (sd1_raw)
	);
	assign sd_d1 = side1_t'(sd1_raw);

	// stage A: S, 5P - S, 5P + 4S
	logic signed [XW-1:0] s_c, p5_c, a_c, d_c;
	logic                 vA_s, a_pos_sA, nd_sA, cz_sA;
	logic [25:0]          a_sA;
	logic signed [XW-1:0] d_sA;

	always_comb begin
		s_c  = signed'(XW'({1'b0, q1})) - signed'(XW'(S_OFF));
		p5_c = signed'(XW'({sd_d1.p, 2'b00})) + signed'(XW'(sd_d1.p));
		a_c  = p5_c - s_c;
		d_c  = p5_c + (s_c <<< 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vA_s <= 1'b0;
		end else if (en) begin
			vA_s <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_pos_sA <= a_c > 0;
			a_sA     <= a_c[25:0];
			d_sA     <= d_c;
			nd_sA    <= sd_d1.no_data;
			cz_sA    <= sd_d1.cn_zero;
		end
	end

	// stage B: numerator square and |5d|
	logic signed [XW+2:0] d5_c;
	logic                 vB_s;
	logic [NUM_W-1:0]     num_sB;
	logic [DW2-1:0]       den_sB;
	side2_t               sd_sB;

	assign d5_c = (signed'((XW+3)'(d_sA)) <<< 2) + signed'((XW+3)'(d_sA));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vB_s <= 1'b0;
		end else if (en) begin
			vB_s <= vA_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_sB         <= a_sA * a_sA;
			den_sB         <= d5_c[XW+2] ? DW2'(-d5_c) : DW2'(d5_c);
			sd_sB.no_data  <= nd_sA;
			sd_sB.zero_res <= cz_sA || !a_pos_sA;
			sd_sB.d_zero   <= d_sA == '0;
			sd_sB.d_neg    <= d_sA[XW-1];
		end
	end

	// runoff divider
	logic                      v_d2;
	logic [NUM_W-1:0]          q2;
	logic [$bits(side2_t)-1:0] sd2_raw;
	side2_t                    sd_d2;

	cnr_div #(.NW(NUM_W), .DW(DW2), .SW($bits(side2_t))) u_div_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vB_s),
		.dividend (num_sB),
		.divisor  (den_sB),
		.in_side  (sd_sB),
		.out_vld  (v_d2),
		.quotient (q2),
		.out_side (sd2_raw)
	);
	assign sd_d2 = side2_t'(sd2_raw);

	// output stage: sign, saturation, no-data select
	runoff_t res_c;

	always_comb begin
		res_c.is_no_data = sd_d2.no_data;
		if (sd_d2.no_data) begin
			res_c.runoff_depth = no_data_q;
		end else if (sd_d2.zero_res) begin
			res_c.runoff_depth = '0;
		end else if (sd_d2.d_zero) begin
			res_c.runoff_depth = MAX24;
		end else if (sd_d2.d_neg) begin
			res_c.runoff_depth = (q2 > NUM_W'(MIN24)) ? MIN24 : -q2[23:0];
		end else begin
			res_c.runoff_depth = (q2 > NUM_W'(MAX24)) ? MAX24 : q2[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runoff_valid <= 1'b0;
		end else if (en) begin
			runoff_valid <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			runoff <= res_c;
		end
	end

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> runoff_valid && runoff_stall)
		else $error("pixel stalled with output register free");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall |=> v_s1)
		else $error("accepted request not captured");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall && v_s1 |=> v_s1 && $stable(cn_s1))
		else $error("first stage moved during stall");
`endif

endmodule
